[sv/rwcs_pkg.sv]
`default_nettype none
package rwcs_pkg;

  localparam int SCREEN_ROWS = 1024;
  localparam int GRID_CELLS  = 1024;

  localparam int DIST_W   = 26;
  localparam int DIR_W    = 19;
  localparam int CELL_W   = 10;
  localparam int FRAC_W   = 16;
  localparam int TEXW_W   = 13;
  localparam int COL_W    = 12;
  localparam int ROWS_W   = 14;
  localparam int ROW_W    = 10;

  localparam logic [DIST_W-1:0] DIST_MIN = DIST_W'(655);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // rows divider: dividend SCREEN_ROWS << 16, divisor at least DIST_MIN
  localparam longint ROWS_NUM = longint'(SCREEN_ROWS) * 65536;
  localparam int     ROWS_QW  = $clog2(ROWS_NUM / 655 + 1);
  localparam int     RCAP_W   = $clog2(10 * SCREEN_ROWS + 1);
  localparam int     SROW_W   = $clog2(SCREEN_ROWS);
  localparam logic [63:0] ROWS_NUM_V = 64'(ROWS_NUM);
  localparam logic [RCAP_W-1:0] ROWS_CAP  = RCAP_W'(10 * SCREEN_ROWS);
  localparam logic [RCAP_W-1:0] ROWS_HALF = RCAP_W'(SCREEN_ROWS / 2);
  localparam logic [RCAP_W-1:0] ROWS_LAST = RCAP_W'(SCREEN_ROWS - 1);

  localparam int LATENCY = DIST_W + ROWS_QW + 8;

  localparam logic [1:0] REG_TEX_NORTH = 2'd0;
  localparam logic [1:0] REG_TEX_SOUTH = 2'd1;
  localparam logic [1:0] REG_TEX_EAST  = 2'd2;
  localparam logic [1:0] REG_TEX_WEST  = 2'd3;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_MIN  = 2'd1,
    CLAMP_MAX  = 2'd2
  } clamp_t;

  typedef struct packed {
    logic              hit_side;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              step_x_neg;
    logic              step_y_neg;
    logic [DIR_W-1:0]  ray_dx;
    logic [DIR_W-1:0]  ray_dy;
    logic [DIST_W-1:0] eye_x;
    logic [DIST_W-1:0] eye_y;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] wall_dist;
    logic [ROWS_W-1:0] wall_rows;
    logic [ROW_W-1:0]  row_first;
    logic [ROW_W-1:0]  row_last;
    logic [FRAC_W-1:0] wall_frac;
    logic [1:0]        face_index;
    logic [COL_W-1:0]  texel_col;
  } result_t;

  typedef struct packed {
    logic [DIR_W-1:0]  sel_d;
    logic [FRAC_W-1:0] e_lo;
    logic [1:0]        face;
    logic              mirror;
  } ctx_t;

endpackage
`default_nettype wire

[sv/raycast_wall_column_setup_core.sv]
// Wall-column setup for a grid raycaster.
// Command channel: item is taken at a clock edge with start high and busy
// low. busy is high only while rst is held; otherwise one item per cycle.
// Result channel: done pulses for one cycle with result valid; the receiver
// takes it at the edge ending that cycle and cannot hold it off.
// An accepted item passes through stage A, the distance divider, the rows
// divider, stage R and stages P1..P4 to the result. Throughput: one item per cycle,
// set by the fully pipelined distance divider (26 stages, one quotient bit each) and
// the wall-height divider (17 stages).
// Configuration: cfg_we with cfg_index 0..3 writes the north, south, east
// and west texture widths; write only while no transaction is in flight.
// Reset: clears all pipeline valid bits and sets every texture width to 64.
`default_nettype none
module raycast_wall_column_setup_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire rwcs_pkg::in_item_t        item,
  output logic                           done,
  output rwcs_pkg::result_t              result,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [rwcs_pkg::TEXW_W-1:0] cfg_data
);

  localparam int DW = rwcs_pkg::DIST_W;
  localparam int QW = rwcs_pkg::ROWS_QW;
  localparam int RW = rwcs_pkg::RCAP_W;

  logic [rwcs_pkg::TEXW_W-1:0] tex_width [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width[0] <= rwcs_pkg::TEXW_W'(64);
      tex_width[1] <= rwcs_pkg::TEXW_W'(64);
      tex_width[2] <= rwcs_pkg::TEXW_W'(64);
      tex_width[3] <= rwcs_pkg::TEXW_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwcs_pkg::REG_TEX_NORTH: tex_width[0] <= cfg_data;
        rwcs_pkg::REG_TEX_SOUTH: tex_width[1] <= cfg_data;
        rwcs_pkg::REG_TEX_EAST:  tex_width[2] <= cfg_data;
        rwcs_pkg::REG_TEX_WEST:  tex_width[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // stage A: numerator and direction select
  logic              a_v;
  logic [27:0]       a_num;
  logic [18:0]       a_dir;
  rwcs_pkg::ctx_t    a_ctx;
  logic [27:0]       num_next;
  rwcs_pkg::ctx_t    ctx_next;

  always_comb begin
    if (!item.hit_side) begin
      num_next = {2'b00, item.cell_x, 16'h0000} - {2'b00, item.eye_x}
               + {11'd0, item.step_x_neg, 16'h0000};
      ctx_next.sel_d  = item.ray_dy;
      ctx_next.e_lo   = item.eye_y[15:0];
      ctx_next.mirror = !item.ray_dx[18] && (item.ray_dx != '0);
      ctx_next.face   = ctx_next.mirror ? rwcs_pkg::FACE_EAST : rwcs_pkg::FACE_WEST;
    end else begin
      num_next = {2'b00, item.cell_y, 16'h0000} - {2'b00, item.eye_y}
               + {11'd0, item.step_y_neg, 16'h0000};
      ctx_next.sel_d  = item.ray_dx;
      ctx_next.e_lo   = item.eye_x[15:0];
      ctx_next.mirror = item.ray_dy[18];
      ctx_next.face   = (!item.ray_dy[18] && (item.ray_dy != '0)) ?
                        rwcs_pkg::FACE_SOUTH : rwcs_pkg::FACE_NORTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else     a_v <= start && !busy;
    a_num <= num_next;
    a_dir <= item.hit_side ? item.ray_dy : item.ray_dx;
    a_ctx <= ctx_next;
  end

  // distance divider: stage 0 sets up, stages 1..DW give one bit each
  logic           d1_v   [DW+1];
  logic [18:0]    d1_rem [DW+1];
  logic [18:0]    d1_ad  [DW+1];
  logic [DW-1:0]  d1_sh  [DW+1];
  logic [DW-1:0]  d1_q   [DW+1];
  rwcs_pkg::clamp_t d1_cl [DW+1];
  rwcs_pkg::ctx_t d1_ctx [DW+1];

  logic [26:0] an;
  logic [18:0] ad;
  rwcs_pkg::clamp_t cl_next;

  always_comb begin
    an = a_num[27] ? 27'(-a_num) : a_num[26:0];
    ad = a_dir[18] ? -a_dir : a_dir;
    if (a_dir == '0)                                cl_next = rwcs_pkg::CLAMP_MAX;
    else if (a_num == '0 || a_num[27] != a_dir[18]) cl_next = rwcs_pkg::CLAMP_MIN;
    else if ({2'b00, an} >= {ad, 10'd0})            cl_next = rwcs_pkg::CLAMP_MAX;
    else                                            cl_next = rwcs_pkg::CLAMP_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) d1_v[0] <= 1'b0;
    else     d1_v[0] <= a_v;
    d1_rem[0] <= {2'b00, an[26:10]};
    d1_ad[0]  <= ad;
    d1_sh[0]  <= {an[9:0], 16'h0000};
    d1_q[0]   <= '0;
    d1_cl[0]  <= cl_next;
    d1_ctx[0] <= a_ctx;
  end

  for (genvar k = 1; k <= DW; k++) begin : g_div1
    logic [19:0] r2;
    logic        ge;
    assign r2 = {d1_rem[k-1], d1_sh[k-1][DW-1]};
    assign ge = r2 >= {1'b0, d1_ad[k-1]};
    always_ff @(posedge clk) begin
      if (rst) d1_v[k] <= 1'b0;
      else     d1_v[k] <= d1_v[k-1];
      d1_rem[k] <= ge ? 19'(r2 - {1'b0, d1_ad[k-1]}) : r2[18:0];
      d1_ad[k]  <= d1_ad[k-1];
      d1_sh[k]  <= {d1_sh[k-1][DW-2:0], 1'b0};
      d1_q[k]   <= {d1_q[k-1][DW-2:0], ge};
      d1_cl[k]  <= d1_cl[k-1];
      d1_ctx[k] <= d1_ctx[k-1];
    end
  end

  // stage C: final distance; rows divider stages 1..QW follow
  logic           d2_v    [QW+1];
  logic [DW-1:0]  d2_rem  [QW+1];
  logic [DW-1:0]  d2_dist [QW+1];
  logic [QW-1:0]  d2_q    [QW+1];
  rwcs_pkg::ctx_t d2_ctx  [QW+1];
  logic [DW-1:0]  dist_next;

  always_comb begin
    unique case (d1_cl[DW])
      rwcs_pkg::CLAMP_MAX: dist_next = rwcs_pkg::DIST_MAX;
      rwcs_pkg::CLAMP_MIN: dist_next = rwcs_pkg::DIST_MIN;
      default: dist_next = (d1_q[DW] < rwcs_pkg::DIST_MIN) ? rwcs_pkg::DIST_MIN : d1_q[DW];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) d2_v[0] <= 1'b0;
    else     d2_v[0] <= d1_v[DW];
    d2_rem[0]  <= DW'(rwcs_pkg::ROWS_NUM_V >> QW);
    d2_dist[0] <= dist_next;
    d2_q[0]    <= '0;
    d2_ctx[0]  <= d1_ctx[DW];
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div2
    logic [DW:0] r2;
    logic        ge;
    assign r2 = {d2_rem[j-1], rwcs_pkg::ROWS_NUM_V[QW-j]};
    assign ge = r2 >= {1'b0, d2_dist[j-1]};
    always_ff @(posedge clk) begin
      if (rst) d2_v[j] <= 1'b0;
      else     d2_v[j] <= d2_v[j-1];
      d2_rem[j]  <= ge ? DW'(r2 - {1'b0, d2_dist[j-1]}) : r2[DW-1:0];
      d2_dist[j] <= d2_dist[j-1];
      d2_q[j]    <= {d2_q[j-1][QW-2:0], ge};
      d2_ctx[j]  <= d2_ctx[j-1];
    end
  end

  // stage R: clamp rows, draw range
  logic           r_v;
  logic [RW-1:0]  r_rows;
  logic [RW-1:0]  r_first;
  logic [RW-1:0]  r_last;
  logic [DW-1:0]  r_dist;
  rwcs_pkg::ctx_t r_ctx;
  logic [RW-1:0]  rows_c;
  logic [RW-1:0]  half;
  logic [RW:0]    lo_sum;

  always_comb begin
    rows_c = (d2_q[QW] > QW'(rwcs_pkg::ROWS_CAP)) ? rwcs_pkg::ROWS_CAP : RW'(d2_q[QW]);
    half   = rows_c >> 1;
    lo_sum = {1'b0, rwcs_pkg::ROWS_HALF} + {1'b0, half};
  end

  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else     r_v <= d2_v[QW];
    r_rows  <= rows_c;
    r_first <= (half > rwcs_pkg::ROWS_HALF) ? '0 : rwcs_pkg::ROWS_HALF - half;
    r_last  <= (lo_sum > {1'b0, rwcs_pkg::ROWS_LAST}) ? rwcs_pkg::ROWS_LAST : lo_sum[RW-1:0];
    r_dist  <= d2_dist[QW];
    r_ctx   <= d2_ctx[QW];
  end

  // stages P1..P4: wall position, texture column
  logic           p1_v, p2_v, p3_v;
  logic [31:0]    p1_prod;
  logic [15:0]    p2_frac;
  logic [12:0]    p3_col;
  logic [12:0]    p3_w;
  logic [RW-1:0]  p1_rows, p2_rows, p3_rows;
  logic [RW-1:0]  p1_first, p2_first, p3_first;
  logic [RW-1:0]  p1_last, p2_last, p3_last;
  logic [DW-1:0]  p1_dist, p2_dist, p3_dist;
  rwcs_pkg::ctx_t p1_ctx, p2_ctx, p3_ctx;
  logic [15:0]    p3_frac;
  logic signed [45:0] prod_full;
  logic [31:0]    pos_lo;
  logic [12:0]    w_raw;
  logic [12:0]    w_eff;
  logic [28:0]    colp;

  assign prod_full = $signed({1'b0, r_dist}) * $signed(r_ctx.sel_d);
  assign pos_lo    = {p1_ctx.e_lo, 16'h0000} + p1_prod;

  always_comb begin
    w_raw = tex_width[p2_ctx.face];
    if (w_raw == '0)              w_eff = 13'd1;
    else if (w_raw > 13'd4096)    w_eff = 13'd4096;
    else                          w_eff = w_raw;
    colp = p2_frac * w_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      done <= 1'b0;
    end else begin
      p1_v <= r_v;
      p2_v <= p1_v;
      p3_v <= p2_v;
      done <= p3_v;
    end
    p1_prod  <= prod_full[31:0];
    p1_rows  <= r_rows;
    p1_first <= r_first;
    p1_last  <= r_last;
    p1_dist  <= r_dist;
    p1_ctx   <= r_ctx;

    p2_frac  <= pos_lo[31:16];
    p2_rows  <= p1_rows;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_dist  <= p1_dist;
    p2_ctx   <= p1_ctx;

    p3_col   <= colp[28:16];
    p3_w     <= w_eff;
    p3_frac  <= p2_frac;
    p3_rows  <= p2_rows;
    p3_first <= p2_first;
    p3_last  <= p2_last;
    p3_dist  <= p2_dist;
    p3_ctx   <= p2_ctx;

    result.wall_dist  <= p3_dist;
    result.wall_rows  <= rwcs_pkg::ROWS_W'(p3_rows);
    result.row_first  <= rwcs_pkg::ROW_W'(p3_first);
    result.row_last   <= rwcs_pkg::ROW_W'(p3_last);
    result.wall_frac  <= p3_frac;
    result.face_index <= p3_ctx.face;
    result.texel_col  <= p3_ctx.mirror ? 12'(p3_w - p3_col - 13'd1) : p3_col[11:0];
  end

endmodule
`default_nettype wire

[sv/rwcs_check.sv]
`default_nettype none
module rwcs_check (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire rwcs_pkg::result_t result
);

  a_busy_reset: assert property (@(posedge clk) busy == rst)
    else $error("busy outside reset");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, rwcs_pkg::LATENCY))
    else $error("result without transaction");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(rwcs_pkg::LATENCY) done)
    else $error("transaction lost");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.wall_dist >= rwcs_pkg::DIST_MIN && result.row_first <= result.row_last))
    else $error("result out of range");

endmodule

bind raycast_wall_column_setup_core rwcs_check u_rwcs_check (.*);
`default_nettype wire

[test/tb_raycast_wall_column_setup_core.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_raycast_wall_column_setup_core;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  rwcs_pkg::in_item_t item;
  logic done;
  rwcs_pkg::result_t result;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [rwcs_pkg::TEXW_W-1:0] cfg_data;

  logic [rwcs_pkg::TEXW_W-1:0] tex_width [4];
  rwcs_pkg::result_t pending_columns [$];
  int fail_count;

  raycast_wall_column_setup_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

  function automatic rwcs_pkg::result_t column_setup(rwcs_pkg::in_item_t c);
    rwcs_pkg::result_t r;
    longint num, dir, dx, dy, ex, ey, pos, q, rows, half, first, last, w, col;
    longint an, ad;
    logic [1:0] face;
    logic mirror;
    dx = longint'(signed'(c.ray_dx));
    dy = longint'(signed'(c.ray_dy));
    ex = longint'(c.eye_x);
    ey = longint'(c.eye_y);
    if (c.hit_side == 1'b0) begin
      num = longint'(c.cell_x) * 65536 - ex + (c.step_x_neg ? 65536 : 0);
      dir = dx;
    end else begin
      num = longint'(c.cell_y) * 65536 - ey + (c.step_y_neg ? 65536 : 0);
      dir = dy;
    end
    if (dir == 0) q = 67108863;
    else if (num == 0 || ((num < 0) != (dir < 0))) q = 655;
    else begin
      an = num < 0 ? -num : num;
      ad = dir < 0 ? -dir : dir;
      q = (an * 65536) / ad;
      if (q < 655) q = 655;
      if (q > 67108863) q = 67108863;
    end
    rows = (longint'(rwcs_pkg::SCREEN_ROWS) * 65536) / q;
    if (rows > 10 * rwcs_pkg::SCREEN_ROWS) rows = 10 * rwcs_pkg::SCREEN_ROWS;
    half = rows / 2;
    first = rwcs_pkg::SCREEN_ROWS / 2 - half;
    if (first < 0) first = 0;
    last = rwcs_pkg::SCREEN_ROWS / 2 + half;
    if (last >= rwcs_pkg::SCREEN_ROWS) last = rwcs_pkg::SCREEN_ROWS - 1;
    if (c.hit_side == 1'b0) pos = ey * 65536 + q * dy;
    else pos = ex * 65536 + q * dx;
    if (c.hit_side == 1'b0) face = dx > 0 ? rwcs_pkg::FACE_EAST : rwcs_pkg::FACE_WEST;
    else face = dy > 0 ? rwcs_pkg::FACE_SOUTH : rwcs_pkg::FACE_NORTH;
    w = longint'(tex_width[face]);
    if (w == 0) w = 1;
    if (w > 4096) w = 4096;
    col = (((pos >>> 16) & 65535) * w) >> 16;
    mirror = (c.hit_side == 1'b0 && dx > 0) || (c.hit_side == 1'b1 && dy < 0);
    if (mirror) col = w - col - 1;
    r.wall_dist = q[rwcs_pkg::DIST_W-1:0];
    r.wall_rows = rows[rwcs_pkg::ROWS_W-1:0];
    r.row_first = first[rwcs_pkg::ROW_W-1:0];
    r.row_last = last[rwcs_pkg::ROW_W-1:0];
    r.wall_frac = pos[31:16];
    r.face_index = face;
    r.texel_col = col[rwcs_pkg::COL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    rwcs_pkg::result_t e;
    if (!rst && done) begin
      if (pending_columns.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %p", $time, result);
        fail_count++;
      end else begin
        e = pending_columns.pop_front();
        if (result.wall_dist !== e.wall_dist) begin
          $display("%0t: wall_dist expected %0d actual %0d", $time, e.wall_dist,
                   result.wall_dist);
          fail_count++;
        end
        if (result.wall_rows !== e.wall_rows) begin
          $display("%0t: wall_rows expected %0d actual %0d", $time, e.wall_rows,
                   result.wall_rows);
          fail_count++;
        end
        if (result.row_first !== e.row_first) begin
          $display("%0t: row_first expected %0d actual %0d", $time, e.row_first,
                   result.row_first);
          fail_count++;
        end
        if (result.row_last !== e.row_last) begin
          $display("%0t: row_last expected %0d actual %0d", $time, e.row_last,
                   result.row_last);
          fail_count++;
        end
        if (result.wall_frac !== e.wall_frac) begin
          $display("%0t: wall_frac expected %0d actual %0d", $time, e.wall_frac,
                   result.wall_frac);
          fail_count++;
        end
        if (result.face_index !== e.face_index) begin
          $display("%0t: face_index expected %0d actual %0d", $time, e.face_index,
                   result.face_index);
          fail_count++;
        end
        if (result.texel_col !== e.texel_col) begin
          $display("%0t: texel_col expected %0d actual %0d", $time, e.texel_col,
                   result.texel_col);
          fail_count++;
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ?
        $urandom_range(1, 3) : $urandom_range(10, 60));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_ray(rwcs_pkg::in_item_t c);
    start <= 1'b1;
    item <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_columns.push_back(column_setup(c));
  endtask

  task automatic send_burst(rwcs_pkg::in_item_t c, bit gaps);
    send_ray(c);
    if (gaps) idle_gap();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_columns.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (rwcs_pkg::LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_width(logic [1:0] idx, logic [rwcs_pkg::TEXW_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    tex_width[idx] = v;
    cfg_we <= 1'b0;
  endtask

  function automatic rwcs_pkg::in_item_t random_ray();
    rwcs_pkg::in_item_t c;
    c = '0;
    c.hit_side = 1'($urandom_range(0, 1));
    c.step_x_neg = 1'($urandom_range(0, 1));
    c.step_y_neg = 1'($urandom_range(0, 1));
    c.ray_dx = 19'($urandom);
    c.ray_dy = 19'($urandom);
    c.eye_x = 26'($urandom);
    c.eye_y = 26'($urandom);
    c.cell_x = 10'($urandom);
    c.cell_y = 10'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      // hit a nearby cell in the stepping direction
      c.cell_x = 10'(c.eye_x[25:16] + (c.step_x_neg ? -$urandom_range(1, 20) :
                 $urandom_range(1, 20)));
      c.cell_y = 10'(c.eye_y[25:16] + (c.step_y_neg ? -$urandom_range(1, 20) :
                 $urandom_range(1, 20)));
      c.ray_dx = 19'(c.step_x_neg ? -$urandom_range(1, 131072) :
                 $urandom_range(1, 131072));
      c.ray_dy = 19'(c.step_y_neg ? -$urandom_range(1, 131072) :
                 $urandom_range(1, 131072));
    end
    if ($urandom_range(0, 15) == 0) c.ray_dx = '0;
    if ($urandom_range(0, 15) == 0) c.ray_dy = '0;
    return c;
  endfunction

  task automatic test_directed();
    rwcs_pkg::in_item_t c;
    c = '0;
    send_burst(c, 0);
    c.hit_side = 1'b1;
    send_burst(c, 0);
    c = '1;
    send_burst(c, 0);
    c.hit_side = 1'b0;
    send_burst(c, 0);
    c = '0;
    c.cell_x = 10'd5;
    c.eye_x = 26'd2 << 16;
    c.eye_y = 26'h0123456;
    c.ray_dx = 19'sd65536;
    c.ray_dy = 19'sd30000;
    send_burst(c, 0);
    c.ray_dx = 19'h40000;
    send_burst(c, 0);
    c.ray_dx = 19'h3FFFF;
    send_burst(c, 0);
    c.ray_dx = 19'd1;
    send_burst(c, 0);
    c.ray_dx = '0;
    send_burst(c, 0);
    c.cell_x = 10'd2;
    c.ray_dx = 19'd100;
    send_burst(c, 0);
    c.cell_x = 10'd3;
    c.ray_dx = 19'h3FFFF;
    send_burst(c, 0);
    c = '0;
    c.hit_side = 1'b1;
    c.cell_y = 10'd1020;
    c.step_y_neg = 1'b1;
    c.eye_y = 26'd3 << 16;
    c.eye_x = 26'h3FFFFFF;
    c.ray_dy = 19'sd1000;
    c.ray_dx = 19'h40000;
    send_burst(c, 0);
    c.ray_dy = -19'sd1000;
    send_burst(c, 0);
    c.cell_y = 10'd0;
    c.eye_y = 26'h3FFFFFF;
    send_burst(c, 0);
    c.ray_dy = '0;
    send_burst(c, 0);
    c.cell_x = 10'h3FF;
    c.eye_x = '0;
    c.step_x_neg = 1'b1;
    c.hit_side = 1'b0;
    c.ray_dx = 19'd7;
    send_burst(c, 0);
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) send_burst(random_ray(), 1);
    drain();
  endtask

  task automatic test_widths();
    write_width(rwcs_pkg::REG_TEX_NORTH, 13'd1);
    write_width(rwcs_pkg::REG_TEX_SOUTH, 13'd4096);
    write_width(rwcs_pkg::REG_TEX_EAST, 13'd0);
    write_width(rwcs_pkg::REG_TEX_WEST, 13'h1FFF);
    test_random(80);
    write_width(rwcs_pkg::REG_TEX_NORTH, 13'd4096);
    write_width(rwcs_pkg::REG_TEX_SOUTH, 13'd1);
    write_width(rwcs_pkg::REG_TEX_EAST, 13'd4096);
    write_width(rwcs_pkg::REG_TEX_WEST, 13'd1);
    test_random(80);
    write_width(rwcs_pkg::REG_TEX_NORTH, 13'($urandom));
    write_width(rwcs_pkg::REG_TEX_SOUTH, 13'($urandom));
    write_width(rwcs_pkg::REG_TEX_EAST, 13'($urandom));
    write_width(rwcs_pkg::REG_TEX_WEST, 13'($urandom_range(1, 4096)));
    test_random(80);
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < 4; i++) tex_width[i] = 13'd64;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= rwcs_pkg::REG_TEX_NORTH;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(260);
    test_widths();
    if (pending_columns.size() != 0) begin
      $display("%0t: %0d transactions outstanding", $time, pending_columns.size());
      fail_count++;
    end
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
sv/rwcs_pkg.sv
sv/raycast_wall_column_setup_core.sv
sv/rwcs_check.sv
test/tb_raycast_wall_column_setup_core.sv
